// ===== rtl/palette_nearest_color_quantizer_macros.svh =====
// ----------------------------------------------------------------------------
// palette_nearest_color_quantizer assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PALETTE_NEAREST_COLOR_QUANTIZER_MACROS_SVH
`define PALETTE_NEAREST_COLOR_QUANTIZER_MACROS_SVH

// same-cycle implication
`define PNQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pnq assertion failed");

// next-cycle implication
`define PNQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pnq assertion failed");

`endif

// ===== rtl/pnq_pkg.sv =====
// ----------------------------------------------------------------------------
// pnq_pkg
// types shared by the palette quantizer cells and top level
// ----------------------------------------------------------------------------
package pnq_pkg;

	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_PIXEL = 1'b1
	} pnq_mode_t;

	localparam int unsigned DIST_W = 10;
	localparam logic [DIST_W-1:0] DIST_INIT = '1;

	typedef struct packed {
		pnq_mode_t  mode;
		logic [7:0] entry_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pnq_in_t;

	typedef struct packed {
		logic [7:0]  color_index;
		logic [3:0]  alpha_level;
		logic [11:0] packed_code;
		logic [9:0]  min_distance;
	} pnq_out_t;

	// what moves from one cell to the next
	typedef struct packed {
		logic              valid;
		pnq_mode_t         mode;
		logic [7:0]        entry_index;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [3:0]        alpha_level;
		logic [7:0]        best_index;
		logic [DIST_W-1:0] best_dist;
	} pnq_token_t;

endpackage

// ===== rtl/palette_nearest_color_quantizer.sv =====
// ----------------------------------------------------------------------------
// palette_nearest_color_quantizer
// nearest palette color search (sum of absolute RGB differences) with alpha
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): mode 0 loads one palette
//   entry, mode 1 quantizes one pixel. result channel (result_valid /
//   result_stall / result) returns one transaction per pixel, none per load.
//   Every item walks a row of PALETTE_ENTRIES cells, one cell per cycle, each
//   cell holding one palette color; a load is taken by its own cell, a pixel
//   keeps the best index and distance seen so far, lowest index on ties.
//   A pixel passes the PALETTE_ENTRIES cell registers, then the result register.
//   Throughput is one item per cycle; loads and pixels may be mixed freely
//   and a pixel sees every load accepted before it.
//   Reset clears the palette to black and empties the row at once.
//   While a result is held by result_stall the whole row freezes and
//   item_stall is raised in the same cycle; nothing is dropped.
//   Writes to entries at or above PALETTE_ENTRIES are ignored.
// ----------------------------------------------------------------------------
module palette_nearest_color_quantizer import pnq_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = 256,
	parameter int unsigned ALPHA_STEP      = 17,
	parameter int unsigned ALPHA_BITS      = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  pnq_in_t  item,
	output logic     result_valid,
	input  logic     result_stall,
	output pnq_out_t result
);

	`include "palette_nearest_color_quantizer_macros.svh"

	localparam int unsigned ALPHA_LIMIT = (ALPHA_BITS >= 4) ? 15 : ((1 << ALPHA_BITS) - 1);

	pnq_token_t link [PALETTE_ENTRIES+1];
	logic       advance;
	logic [3:0] in_level;
	logic       result_valid_q;
	pnq_out_t   result_q;
	pnq_token_t chain_out;
	logic [15:0] shifted_index;

	assign advance    = !(result_valid_q && result_stall);
	assign item_stall = !advance;

	pnq_alpha_quant #(
		.ALPHA_STEP(ALPHA_STEP),
		.ALPHA_BITS(ALPHA_BITS)
	) u_alpha (
		.alpha(item.alpha),
		.level(in_level)
	);

	always_comb begin
		link[0].valid       = item_valid;
		link[0].mode        = item.mode;
		link[0].entry_index = item.entry_index;
		link[0].red         = item.red;
		link[0].green       = item.green;
		link[0].blue        = item.blue;
		link[0].alpha_level = in_level;
		link[0].best_index  = '0;
		link[0].best_dist   = DIST_INIT;
	end

	for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
		pnq_cell #(
			.CELL_INDEX(8'(k))
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(advance),
			.tok_in(link[k]),
			.tok_out(link[k+1])
		);
	end

	assign chain_out     = link[PALETTE_ENTRIES];
	assign shifted_index = 16'(chain_out.best_index) << ALPHA_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= chain_out.valid && (chain_out.mode == MODE_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.color_index  <= chain_out.best_index;
			result_q.alpha_level  <= chain_out.alpha_level;
			result_q.packed_code  <= shifted_index[11:0] | 12'(chain_out.alpha_level);
			result_q.min_distance <= chain_out.best_dist;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`PNQ_ASSERT_NEXT(a_pixel_reaches_output,
		chain_out.valid && (chain_out.mode == MODE_PIXEL) && advance, result_valid)
	`PNQ_ASSERT_IMPL(a_index_in_palette, result_valid,
		result.color_index <= 8'(PALETTE_ENTRIES - 1))
	`PNQ_ASSERT_IMPL(a_level_saturated, result_valid, result.alpha_level <= 4'(ALPHA_LIMIT))
	`PNQ_ASSERT_IMPL(a_distance_range, result_valid, result.min_distance <= 10'd765)

endmodule

// ===== rtl/pnq_alpha_quant.sv =====
// ----------------------------------------------------------------------------
// pnq_alpha_quant
// constant lookup from 8-bit alpha to saturated alpha level, rounded up past 3/10 of a step
// ----------------------------------------------------------------------------
module pnq_alpha_quant #(
	parameter int unsigned ALPHA_STEP = 17,
	parameter int unsigned ALPHA_BITS = 4
) (
	input  logic [7:0] alpha,
	output logic [3:0] level
);

	localparam int unsigned ALPHA_LIMIT = (ALPHA_BITS >= 4) ? 15 : ((1 << ALPHA_BITS) - 1);

	logic [3:0] level_lut [256];

	for (genvar i = 0; i < 256; i++) begin : g_lut
		localparam int unsigned Q = i / ALPHA_STEP;
		localparam int unsigned R = i % ALPHA_STEP;
		localparam int unsigned QR = (10 * R > 3 * ALPHA_STEP) ? Q + 1 : Q;
		localparam int unsigned QS = (QR > ALPHA_LIMIT) ? ALPHA_LIMIT : QR;
		assign level_lut[i] = 4'(QS);
	end

	assign level = level_lut[alpha];

endmodule

// ===== rtl/pnq_cell.sv =====
// ----------------------------------------------------------------------------
// pnq_cell
// one palette entry: takes its own load, scores passing pixels against it
// ----------------------------------------------------------------------------
module pnq_cell import pnq_pkg::*; #(
	parameter logic [7:0] CELL_INDEX = 8'd0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  pnq_token_t tok_in,
	output pnq_token_t tok_out
);

	logic [7:0] red_q, green_q, blue_q;
	pnq_token_t tok_q;
	logic [7:0] ad_r, ad_g, ad_b;
	logic [DIST_W-1:0] sum_dist;
	logic load_hit, take;

	assign ad_r = (tok_in.red   > red_q)   ? tok_in.red   - red_q   : red_q   - tok_in.red;
	assign ad_g = (tok_in.green > green_q) ? tok_in.green - green_q : green_q - tok_in.green;
	assign ad_b = (tok_in.blue  > blue_q)  ? tok_in.blue  - blue_q  : blue_q  - tok_in.blue;
	assign sum_dist = DIST_W'(ad_r) + DIST_W'(ad_g) + DIST_W'(ad_b);

	assign load_hit = tok_in.valid && (tok_in.mode == MODE_LOAD)
		&& (tok_in.entry_index == CELL_INDEX);
	assign take = (tok_in.mode == MODE_PIXEL) && (sum_dist < tok_in.best_dist);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
		end else if (en && load_hit) begin
			red_q   <= tok_in.red;
			green_q <= tok_in.green;
			blue_q  <= tok_in.blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (en) begin
			tok_q.valid       <= tok_in.valid;
			tok_q.mode        <= tok_in.mode;
			tok_q.entry_index <= tok_in.entry_index;
			tok_q.red         <= tok_in.red;
			tok_q.green       <= tok_in.green;
			tok_q.blue        <= tok_in.blue;
			tok_q.alpha_level <= tok_in.alpha_level;
			tok_q.best_index  <= take ? CELL_INDEX : tok_in.best_index;
			tok_q.best_dist   <= take ? sum_dist : tok_in.best_dist;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== tb/palette_nearest_color_quantizer_test.sv =====
// ----------------------------------------------------------------------------
// palette_nearest_color_quantizer_test
// Loads palette entries and streams pixels through the quantizer while both
// the item and the result channels stall at random. A shadow copy of the
// palette predicts the nearest index, alpha level, packed code and distance
// of every pixel transaction; results are checked in order, field by field.
// ----------------------------------------------------------------------------
module palette_nearest_color_quantizer_test;
	import pnq_pkg::*;

	localparam int unsigned PALETTE_ENTRIES = 256;
	localparam int unsigned ALPHA_STEP      = 17;
	localparam int unsigned ALPHA_BITS      = 4;
	localparam int unsigned LATENCY         = PALETTE_ENTRIES + 1;
	localparam int unsigned CLK_PERIOD      = 20;
	localparam int unsigned RANDOM_ITEMS    = 1500;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	class palette_shadow;
		rgb_t        colors [PALETTE_ENTRIES];
		pnq_out_t    pending_codes [$];
		int unsigned mismatches;

		function new();
			foreach (colors[j])
				colors[j] = '0;
			mismatches = 0;
		endfunction

		function int unsigned gap_of(logic [7:0] a, logic [7:0] b);
			return (a > b) ? int'(a - b) : int'(b - a);
		endfunction

		function pnq_out_t nearest_color(pnq_in_t px);
			pnq_out_t    o;
			int unsigned d;
			int unsigned best_d;
			int unsigned best;
			int unsigned q;
			int unsigned rem;
			int unsigned limit;
			best_d = 32'hFFFF_FFFF;
			best = 0;
			for (int unsigned j = 0; j < PALETTE_ENTRIES; j++) begin
				d = gap_of(px.red, colors[j].red) + gap_of(px.green, colors[j].green)
					+ gap_of(px.blue, colors[j].blue);
				if (d < best_d) begin
					best_d = d;
					best = j;
				end
			end
			q = px.alpha / ALPHA_STEP;
			rem = px.alpha % ALPHA_STEP;
			if (10 * rem > 3 * ALPHA_STEP)
				q++;
			limit = (ALPHA_BITS >= 8) ? 255 : (1 << ALPHA_BITS) - 1;
			if (limit > 15)
				limit = 15;
			if (q > limit)
				q = limit;
			o.color_index = best[7:0];
			o.alpha_level = q[3:0];
			o.packed_code = 12'((best << ALPHA_BITS) | q);
			o.min_distance = 10'(best_d);
			return o;
		endfunction

		// note one accepted item transaction
		function void take_item(pnq_in_t it);
			if (it.mode == MODE_LOAD) begin
				if (it.entry_index < PALETTE_ENTRIES)
					colors[it.entry_index] = '{it.red, it.green, it.blue};
			end else begin
				pending_codes.push_back(nearest_color(it));
			end
		endfunction

		// compare one accepted result transaction with the oldest prediction
		function void check_result(pnq_out_t got);
			pnq_out_t want;
			if (pending_codes.size() == 0) begin
				$error("result transaction with no pixel pending");
				mismatches++;
				return;
			end
			want = pending_codes.pop_front();
			if (got.color_index !== want.color_index) begin
				$error("color_index expected %0d got %0d", want.color_index, got.color_index);
				mismatches++;
			end
			if (got.alpha_level !== want.alpha_level) begin
				$error("alpha_level expected %0d got %0d", want.alpha_level, got.alpha_level);
				mismatches++;
			end
			if (got.packed_code !== want.packed_code) begin
				$error("packed_code expected %0d got %0d", want.packed_code, got.packed_code);
				mismatches++;
			end
			if (got.min_distance !== want.min_distance) begin
				$error("min_distance expected %0d got %0d", want.min_distance,
					got.min_distance);
				mismatches++;
			end
		endfunction
	endclass

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     item_valid   = 1'b0;
	logic     item_stall;
	pnq_in_t  item         = '0;
	logic     result_valid;
	logic     result_stall = 1'b0;
	pnq_out_t result;

	palette_shadow shadow = new();
	bit            sender_calm;

	palette_nearest_color_quantizer #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES),
		.ALPHA_STEP     (ALPHA_STEP),
		.ALPHA_BITS     (ALPHA_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// mostly short, now and then long
	function automatic int unsigned idle_cycles();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		if (pick < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 120);
	endfunction

	function automatic pnq_in_t make_item(pnq_mode_t mode, logic [7:0] index,
			logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
		pnq_in_t it;
		it.mode = mode;
		it.entry_index = index;
		it.red = r;
		it.green = g;
		it.blue = b;
		it.alpha = a;
		return it;
	endfunction

	function automatic logic [7:0] nudge(logic [7:0] c);
		int v;
		v = int'(c) + int'($urandom_range(0, 16)) - 8;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	// loads, some repeating a color already held; pixels random, near or on an entry
	function automatic pnq_in_t random_item();
		pnq_in_t     it;
		rgb_t        base;
		int unsigned pick;
		base = shadow.colors[$urandom_range(0, PALETTE_ENTRIES - 1)];
		pick = $urandom_range(0, 99);
		it.entry_index = 8'($urandom_range(0, 255));
		it.alpha = 8'($urandom_range(0, 255));
		{it.red, it.green, it.blue} = 24'($urandom);
		if (pick < 25) begin
			it.mode = MODE_LOAD;
			if (pick < 8)
				{it.red, it.green, it.blue} = base;
		end else begin
			it.mode = MODE_PIXEL;
			if (pick < 55) begin
				it.red = nudge(base.red);
				it.green = nudge(base.green);
				it.blue = nudge(base.blue);
			end else if (pick < 70) begin
				{it.red, it.green, it.blue} = base;
			end
		end
		return it;
	endfunction

	task automatic send_item(pnq_in_t it);
		int unsigned gap;
		gap = sender_calm ? 0 : idle_cycles();
		repeat (gap) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (item_stall);
		shadow.take_item(it);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (shadow.pending_codes.size() != 0);
	endtask

	task automatic watch_result();
		@(posedge clk);
		if (result_valid && !result_stall)
			shadow.check_result(result);
	endtask

	initial begin
		int unsigned hold;
		int unsigned seg;
		bit          free_run;
		seg = 0;
		free_run = 1'b0;
		forever begin
			if (seg == 0) begin
				free_run = ($urandom_range(0, 3) == 0);
				seg = $urandom_range(50, 400);
			end
			hold = free_run ? 0 : idle_cycles();
			repeat (hold) begin
				result_stall <= 1'b1;
				watch_result();
			end
			result_stall <= 1'b0;
			watch_result();
			seg--;
		end
	end

	initial begin
		pnq_in_t directed [$];
		directed = '{
			make_item(MODE_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0),
			make_item(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd255),
			make_item(MODE_PIXEL, 8'h00, 8'd1, 8'd2, 8'd3, 8'd5),
			make_item(MODE_PIXEL, 8'h00, 8'd4, 8'd5, 8'd6, 8'd6),
			make_item(MODE_PIXEL, 8'h00, 8'd7, 8'd8, 8'd9, 8'd22),
			make_item(MODE_PIXEL, 8'h00, 8'd10, 8'd11, 8'd12, 8'd23),
			make_item(MODE_LOAD, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
			make_item(MODE_PIXEL, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'd254),
			make_item(MODE_LOAD, 8'd128, 8'd128, 8'd0, 8'd255, 8'h00),
			make_item(MODE_LOAD, 8'd1, 8'd0, 8'd0, 8'd0, 8'h00),
			make_item(MODE_PIXEL, 8'h00, 8'd0, 8'd0, 8'd0, 8'd253),
			make_item(MODE_LOAD, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55),
			make_item(MODE_LOAD, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA),
			make_item(MODE_LOAD, 8'd10, 8'd10, 8'd0, 8'd0, 8'h00),
			make_item(MODE_LOAD, 8'd20, 8'd30, 8'd0, 8'd0, 8'h00),
			make_item(MODE_PIXEL, 8'h00, 8'd20, 8'd0, 8'd0, 8'd17),
			make_item(MODE_LOAD, 8'd64, 8'd100, 8'd100, 8'd100, 8'h00),
			make_item(MODE_LOAD, 8'd65, 8'd100, 8'd100, 8'd100, 8'h00),
			make_item(MODE_PIXEL, 8'h00, 8'd101, 8'd99, 8'd100, 8'd34),
			make_item(MODE_PIXEL, 8'h00, 8'd200, 8'd200, 8'd200, 8'd128),
			make_item(MODE_LOAD, 8'd255, 8'd0, 8'd0, 8'd0, 8'h00),
			make_item(MODE_PIXEL, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'd255),
			make_item(MODE_PIXEL, 8'h00, 8'd0, 8'd255, 8'd0, 8'd51)
		};
		sender_calm = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[n])
			send_item(directed[n]);
		wait_drained();
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				sender_calm = ($urandom_range(0, 3) == 0);
			if (n % 300 == 150)
				wait_drained();
			send_item(random_item());
		end
		wait_drained();
		repeat (LATENCY + 8) @(posedge clk);
		if (shadow.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * 2_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
